// ===== hdl/tsr_pkg.sv =====
// Package for the TCP stream reassembler: sequencer states, opcodes and the
// request bundle of the shared adder. No dependencies.
`default_nettype none

package tsr_pkg;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_END     = 2'd1,
    OP_POP     = 2'd2
  } tsr_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIFF_A,
    ST_DIFF_D,
    ST_CHECK,
    ST_MARK,
    ST_ADV_RD,
    ST_ADV_CHK,
    ST_POP_RD,
    ST_POP_UPD,
    ST_END_A,
    ST_END_F
  } tsr_state_e;

  typedef struct packed {
    logic [31:0] opa;
    logic [31:0] opb;
    logic        sub;
  } alu_req_t;

endpackage

`default_nettype wire

// ===== hdl/tcp_stream_reassembler.sv =====
// TCP byte stream reassembler: a sequencer around one shared 32-bit adder.
// Each item steps through the sequencer states; an in-window segment byte also extends
// the assembled run one slot at a time, and a stalled result holds the sequencer until
// the output register is free.
// One item is in flight at a time; the next is taken the cycle after the result loads.
// After reset every valid mark is swept clear while in_stall_o is high.
`default_nettype none

module tcp_stream_reassembler #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] stream_index_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        byte_stored_o,
  output logic        pop_valid_o,
  output logic [7:0]  pop_byte_o,
  output logic [31:0] ack_position_o,
  output logic [12:0] unassembled_count_o,
  output logic [12:0] buffered_count_o,
  output logic        stream_ended_o
);
  import tsr_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned AW = $clog2(CAPACITY + 1);
  localparam logic [SW:0]   CAP_W  = (SW + 1)'(CAPACITY);
  localparam logic [AW-1:0] CAP_A  = AW'(CAPACITY);
  localparam logic [31:0]   CAP_32 = 32'(CAPACITY);
  localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);

  function automatic logic [SW-1:0] ring_add(logic [SW-1:0] base, logic [SW-1:0] ofs);
    logic [SW:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= CAP_W) begin
      s = s - CAP_W;
    end
    return s[SW-1:0];
  endfunction

  tsr_state_e state_q, state_d;

  logic [31:0]   ne_q, ne_d;
  logic [31:0]   rp_q, rp_d;
  logic [31:0]   fl_q, fl_d;
  logic          known_q, known_d;
  logic [AW-1:0] pend_q, pend_d;
  logic [SW-1:0] rslot_q, rslot_d;
  logic [AW-1:0] a_q, a_d;
  logic [SW-1:0] clr_q, clr_d;
  logic          stored_q, stored_d;
  logic          pvalid_q, pvalid_d;
  logic [7:0]    pbyte_q, pbyte_d;

  // Per-item payload and scratch, no reset needed.
  logic [31:0]   idx_q, idx_d;
  logic [7:0]    data_q, data_d;
  logic [31:0]   d_q, d_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] scan_q, scan_d;

  logic          ov_q, ov_d;
  logic          o_stored_q, o_stored_d;
  logic          o_pvalid_q, o_pvalid_d;
  logic [7:0]    o_pbyte_q, o_pbyte_d;
  logic [31:0]   o_ack_q, o_ack_d;
  logic [12:0]   o_unasm_q, o_unasm_d;
  logic [12:0]   o_buf_q, o_buf_d;
  logic          o_ended_q, o_ended_d;

  alu_req_t      alu_req;
  logic [31:0]   alu_res;

  logic          bwe;
  logic [SW-1:0] bwaddr, braddr;
  logic [7:0]    brdata;
  logic          vwe;
  logic [SW-1:0] vwaddr, vraddr;
  logic          vwdata, vrdata;

  logic [SW-1:0]  chk_slot;
  logic [AW+12:0] pend_ext, a_ext;

  tsr_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  tsr_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_bytes (
    .clk_i   (clk_i),
    .we_i    (bwe),
    .waddr_i (bwaddr),
    .wdata_i (data_q),
    .raddr_i (braddr),
    .rdata_o (brdata)
  );

  tsr_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_marks (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (vwdata),
    .raddr_i (vraddr),
    .rdata_o (vrdata)
  );

  assign chk_slot = ring_add(rslot_q, d_q[SW-1:0]);
  assign pend_ext = {13'd0, pend_q};
  assign a_ext    = {13'd0, a_q};
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    ne_d       = ne_q;
    rp_d       = rp_q;
    fl_d       = fl_q;
    known_d    = known_q;
    pend_d     = pend_q;
    rslot_d    = rslot_q;
    a_d        = a_q;
    clr_d      = clr_q;
    stored_d   = stored_q;
    pvalid_d   = pvalid_q;
    pbyte_d    = pbyte_q;
    idx_d      = idx_q;
    data_d     = data_q;
    d_d        = d_q;
    slot_d     = slot_q;
    scan_d     = scan_q;
    ov_d       = ov_q;
    o_stored_d = o_stored_q;
    o_pvalid_d = o_pvalid_q;
    o_pbyte_d  = o_pbyte_q;
    o_ack_d    = o_ack_q;
    o_unasm_d  = o_unasm_q;
    o_buf_d    = o_buf_q;
    o_ended_d  = o_ended_q;

    alu_req = '{opa: ne_q, opb: rp_q, sub: 1'b1};
    bwe     = 1'b0;
    bwaddr  = slot_q;
    braddr  = rslot_q;
    vwe     = 1'b0;
    vwaddr  = slot_q;
    vwdata  = 1'b0;
    vraddr  = scan_q;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        vwe    = 1'b1;
        vwaddr = clr_q;
        clr_d  = clr_q + SW'(1);
        if (clr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d    = stream_index_i;
          data_d   = data_byte_i;
          stored_d = 1'b0;
          pvalid_d = 1'b0;
          pbyte_d  = 8'd0;
          unique case (opcode_i)
            OP_SEGMENT: state_d = ST_DIFF_A;
            OP_END: begin
              fl_d    = stream_index_i;
              known_d = 1'b1;
              state_d = ST_END_A;
            end
            OP_POP:  state_d = ST_POP_RD;
            default: state_d = ST_END_A;
          endcase
        end
      end
      ST_DIFF_A: begin
        a_d     = alu_res[AW-1:0];
        state_d = ST_DIFF_D;
      end
      ST_DIFF_D: begin
        alu_req.opa = idx_q;
        d_d         = alu_res;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        vraddr = chk_slot;
        slot_d = chk_slot;
        if (d_q >= 32'(a_q) && d_q < CAP_32) begin
          state_d = ST_MARK;
        end else begin
          state_d = ST_END_A;
        end
      end
      ST_MARK: begin
        bwe      = 1'b1;
        vwe      = 1'b1;
        vwdata   = 1'b1;
        stored_d = 1'b1;
        if (!vrdata) begin
          pend_d = pend_q + AW'(1);
        end
        // The window check guarantees the assembled length is below capacity here.
        scan_d  = ring_add(rslot_q, a_q[SW-1:0]);
        state_d = ST_ADV_RD;
      end
      ST_ADV_RD: begin
        vraddr = scan_q;
        if (a_q < CAP_A) begin
          state_d = ST_ADV_CHK;
        end else begin
          state_d = ST_END_A;
        end
      end
      ST_ADV_CHK: begin
        if (vrdata) begin
          vwe    = 1'b1;
          vwaddr = scan_q;
          if (pend_q != '0) begin
            pend_d = pend_q - AW'(1);
          end
          alu_req = '{opa: ne_q, opb: 32'd1, sub: 1'b0};
          ne_d    = alu_res;
          a_d     = a_q + AW'(1);
          scan_d  = ring_add(scan_q, SW'(1));
          state_d = ST_ADV_RD;
        end else begin
          state_d = ST_END_A;
        end
      end
      ST_POP_RD: begin
        if (ne_q != rp_q) begin
          state_d = ST_POP_UPD;
        end else begin
          state_d = ST_END_A;
        end
      end
      ST_POP_UPD: begin
        pbyte_d  = brdata;
        pvalid_d = 1'b1;
        alu_req  = '{opa: rp_q, opb: 32'd1, sub: 1'b0};
        rp_d     = alu_res;
        rslot_d  = ring_add(rslot_q, SW'(1));
        state_d  = ST_END_A;
      end
      ST_END_A: begin
        a_d     = alu_res[AW-1:0];
        state_d = ST_END_F;
      end
      ST_END_F: begin
        alu_req.opa = fl_q;
        // Hold here until the output register is free.
        if (!ov_q || !out_stall_i) begin
          ov_d       = 1'b1;
          o_stored_d = stored_q;
          o_pvalid_d = pvalid_q;
          o_pbyte_d  = pbyte_q;
          o_ack_d    = ne_q;
          o_unasm_d  = pend_ext[12:0];
          o_buf_d    = a_ext[12:0];
          o_ended_d  = known_q && (alu_res <= 32'(a_q));
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ne_q       <= '0;
      rp_q       <= '0;
      fl_q       <= '0;
      known_q    <= 1'b0;
      pend_q     <= '0;
      rslot_q    <= '0;
      a_q        <= '0;
      clr_q      <= '0;
      stored_q   <= 1'b0;
      pvalid_q   <= 1'b0;
      pbyte_q    <= '0;
      ov_q       <= 1'b0;
      o_stored_q <= 1'b0;
      o_pvalid_q <= 1'b0;
      o_pbyte_q  <= '0;
      o_ack_q    <= '0;
      o_unasm_q  <= '0;
      o_buf_q    <= '0;
      o_ended_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ne_q       <= ne_d;
      rp_q       <= rp_d;
      fl_q       <= fl_d;
      known_q    <= known_d;
      pend_q     <= pend_d;
      rslot_q    <= rslot_d;
      a_q        <= a_d;
      clr_q      <= clr_d;
      stored_q   <= stored_d;
      pvalid_q   <= pvalid_d;
      pbyte_q    <= pbyte_d;
      ov_q       <= ov_d;
      o_stored_q <= o_stored_d;
      o_pvalid_q <= o_pvalid_d;
      o_pbyte_q  <= o_pbyte_d;
      o_ack_q    <= o_ack_d;
      o_unasm_q  <= o_unasm_d;
      o_buf_q    <= o_buf_d;
      o_ended_q  <= o_ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    data_q <= data_d;
    d_q    <= d_d;
    slot_q <= slot_d;
    scan_q <= scan_d;
  end

  assign out_valid_o         = ov_q;
  assign byte_stored_o       = o_stored_q;
  assign pop_valid_o         = o_pvalid_q;
  assign pop_byte_o          = o_pbyte_q;
  assign ack_position_o      = o_ack_q;
  assign unassembled_count_o = o_unasm_q;
  assign buffered_count_o    = o_buf_q;
  assign stream_ended_o      = o_ended_q;

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CAP_A)
    else $error("pending count exceeds ring capacity");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_END_F) |-> (a_q <= CAP_A))
    else $error("assembled length exceeds ring capacity");

  a_ack_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ne_q != $past(ne_q)) |-> (ne_q == $past(ne_q) + 32'd1))
    else $error("next expected index moved by more than one");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(byte_stored_o && pop_valid_o))
    else $error("result reports both a stored byte and a pop");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_END_F) |=> (ov_q || !$past(ov_q) ||
      !$past(out_stall_i) || ov_q == $past(ov_q)))
    else $error("held result was dropped while the sequencer was busy");
`endif

endmodule

`default_nettype wire

// ===== hdl/tsr_alu.sv =====
// Shared 32-bit add/subtract unit used by the reassembler sequencer.
// Depends on tsr_pkg for the request bundle.
`default_nettype none

module tsr_alu (
  input  tsr_pkg::alu_req_t req_i,
  output logic [31:0]       res_o
);
  import tsr_pkg::*;

  logic [31:0] opb_eff;

  assign opb_eff = req_i.sub ? ~req_i.opb : req_i.opb;
  assign res_o   = req_i.opa + opb_eff + 32'(req_i.sub);

endmodule

`default_nettype wire

// ===== hdl/tsr_ram.sv =====
// Simple dual-port memory: one write port, one read port with registered data.
// Holds the ring bytes and the per-byte valid marks. No dependencies.
`default_nettype none

module tsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
